/* sv/abbt_pkg.sv */
// ----------------------------------------------------------------------------
// abbt_pkg
// Shared types, constants and helpers for the affine bounding box core.
// ----------------------------------------------------------------------------
package abbt_pkg;

  // Fixed-point format
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Product and sum widths
  localparam int PROD_W = 2 * COORD_WIDTH;
  localparam int SHP_W  = PROD_W - FRAC_BITS;   // product after the floor shift
  localparam int SUM_W  = SHP_W + 2;            // two products plus an offset

  // 1.0 in the fixed-point format
  localparam logic signed [COORD_WIDTH-1:0] FIX_ONE =
    {{(COORD_WIDTH-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // Saturation limits, sign-extended to the sum width
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN =
    {{(SUM_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  // Register file indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_XX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_YX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_XY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_YY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd5;

  // Input beat
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] in_x1;
    logic signed [COORD_WIDTH-1:0] in_y1;
    logic signed [COORD_WIDTH-1:0] in_x2;
    logic signed [COORD_WIDTH-1:0] in_y2;
  } box_in_t;

  // Result beat
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x1;
    logic signed [COORD_WIDTH-1:0] out_y1;
    logic signed [COORD_WIDTH-1:0] out_x2;
    logic signed [COORD_WIDTH-1:0] out_y2;
    logic                          box_exact;
  } box_out_t;

  // Matrix and offset registers
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] xx;
    logic signed [COORD_WIDTH-1:0] yx;
    logic signed [COORD_WIDTH-1:0] xy;
    logic signed [COORD_WIDTH-1:0] yy;
    logic signed [COORD_WIDTH-1:0] ox;
    logic signed [COORD_WIDTH-1:0] oy;
  } coef_t;

  // Path selection flags that travel with a box
  typedef struct packed {
    logic shear_free;
    logic xx_one;
    logic yy_one;
  } path_t;

  // Mapped corners: 0=(x1,y1) 1=(x2,y1) 2=(x1,y2) 3=(x2,y2)
  typedef struct packed {
    logic [3:0][COORD_WIDTH-1:0] qx;
    logic [3:0][COORD_WIDTH-1:0] qy;
  } corners_t;

  // Exact signed product, shifted right with floor
  function automatic logic signed [SHP_W-1:0] mul_shift(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b);
    return p[PROD_W-1:FRAC_BITS];
  endfunction

  // Sum of two shifted products and an offset, saturated
  function automatic logic signed [COORD_WIDTH-1:0] sum_sat(
    input logic signed [SHP_W-1:0]       pa,
    input logic signed [SHP_W-1:0]       pb,
    input logic signed [COORD_WIDTH-1:0] off
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(pa) + SUM_W'(pb) + SUM_W'(off);
    if (s > SAT_MAX) return SAT_MAX[COORD_WIDTH-1:0];
    if (s < SAT_MIN) return SAT_MIN[COORD_WIDTH-1:0];
    return s[COORD_WIDTH-1:0];
  endfunction

endpackage

/* sv/abbt_map.sv */
// ----------------------------------------------------------------------------
// abbt_map
// Two-stage corner mapper: eight floor-shifted products, then the four
// corners' sums with offset and saturation.
// ----------------------------------------------------------------------------
module abbt_map (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  abbt_pkg::box_in_t in_box,
  input  abbt_pkg::coef_t   coef,
  output logic              out_valid,
  output abbt_pkg::path_t   out_path,
  output abbt_pkg::corners_t out_corners
);
  import abbt_pkg::*;

  typedef struct packed {
    logic signed [SHP_W-1:0] xx1;
    logic signed [SHP_W-1:0] xx2;
    logic signed [SHP_W-1:0] xy1;
    logic signed [SHP_W-1:0] xy2;
    logic signed [SHP_W-1:0] yx1;
    logic signed [SHP_W-1:0] yx2;
    logic signed [SHP_W-1:0] yy1;
    logic signed [SHP_W-1:0] yy2;
  } prod_t;

  logic     v1_r, v2_r;
  prod_t    prod_r, prod_nxt;
  path_t    path1_r, path2_r, path_nxt;
  corners_t crn_r, crn_nxt;

  // Stage 1: products of every coefficient with the coordinates it meets
  always_comb begin
    prod_nxt.xx1 = mul_shift(coef.xx, in_box.in_x1);
    prod_nxt.xx2 = mul_shift(coef.xx, in_box.in_x2);
    prod_nxt.xy1 = mul_shift(coef.xy, in_box.in_y1);
    prod_nxt.xy2 = mul_shift(coef.xy, in_box.in_y2);
    prod_nxt.yx1 = mul_shift(coef.yx, in_box.in_x1);
    prod_nxt.yx2 = mul_shift(coef.yx, in_box.in_x2);
    prod_nxt.yy1 = mul_shift(coef.yy, in_box.in_y1);
    prod_nxt.yy2 = mul_shift(coef.yy, in_box.in_y2);
    path_nxt.shear_free = (coef.xy == '0) && (coef.yx == '0);
    path_nxt.xx_one     = (coef.xx == FIX_ONE);
    path_nxt.yy_one     = (coef.yy == FIX_ONE);
  end

  // Stage 2: corner sums; a shear-free matrix gives zero cross products
  always_comb begin
    crn_nxt.qx[0] = sum_sat(prod_r.xx1, prod_r.xy1, coef.ox);
    crn_nxt.qx[1] = sum_sat(prod_r.xx2, prod_r.xy1, coef.ox);
    crn_nxt.qx[2] = sum_sat(prod_r.xx1, prod_r.xy2, coef.ox);
    crn_nxt.qx[3] = sum_sat(prod_r.xx2, prod_r.xy2, coef.ox);
    crn_nxt.qy[0] = sum_sat(prod_r.yx1, prod_r.yy1, coef.oy);
    crn_nxt.qy[1] = sum_sat(prod_r.yx2, prod_r.yy1, coef.oy);
    crn_nxt.qy[2] = sum_sat(prod_r.yx1, prod_r.yy2, coef.oy);
    crn_nxt.qy[3] = sum_sat(prod_r.yx2, prod_r.yy2, coef.oy);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    path1_r <= path_nxt;
    crn_r   <= crn_nxt;
    path2_r <= path1_r;
  end

  assign out_valid   = v2_r;
  assign out_path    = path2_r;
  assign out_corners = crn_r;

endmodule

/* sv/affine_bounding_box_transform_core.sv */
// ----------------------------------------------------------------------------
// affine_bounding_box_transform_core
// Axis-aligned bounding box of a box mapped through a 2D affine matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a box beat (in_box) is taken at a clock edge where start
//   is high and busy is low. busy is low whenever the block is out of reset,
//   so one box may enter every cycle.
//   Result channel: out_valid strobes for one cycle with the bounds and the
//   box_exact flag on out_res. The receiver cannot stall; none is needed.
//   From the accepting edge to the strobe, a box passes the registered
//   multiply stage, sum/saturate stage and bounds stage.
//   Throughput is one box per cycle.
//   Configuration: cfg_valid/cfg_ready write cfg_data into the register
//   named by cfg_index (0 coef_xx, 1 coef_yx, 2 coef_xy, 3 coef_yy,
//   4 offset_x, 5 offset_y); other indexes are ignored. cfg_ready is always
//   high. Write only while no box is in flight.
//   Reset: synchronous, rst_n low. The matrix returns to identity with zero
//   offset and all in-flight boxes are dropped; busy is high during reset.
// ----------------------------------------------------------------------------
module affine_bounding_box_transform_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  abbt_pkg::box_in_t                  in_box,
  output logic                               out_valid,
  output abbt_pkg::box_out_t                 out_res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [abbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [abbt_pkg::COORD_WIDTH-1:0]   cfg_data
);
  import abbt_pkg::*;

  coef_t    coef_r;
  logic     map_valid;
  path_t    map_path;
  corners_t crn;

  logic     out_valid_r;
  box_out_t out_res_r, out_res_nxt;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.xx <= FIX_ONE;
      coef_r.yx <= '0;
      coef_r.xy <= '0;
      coef_r.yy <= FIX_ONE;
      coef_r.ox <= '0;
      coef_r.oy <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COEF_XX:  coef_r.xx <= cfg_data;
        CFG_COEF_YX:  coef_r.yx <= cfg_data;
        CFG_COEF_XY:  coef_r.xy <= cfg_data;
        CFG_COEF_YY:  coef_r.yy <= cfg_data;
        CFG_OFFSET_X: coef_r.ox <= cfg_data;
        CFG_OFFSET_Y: coef_r.oy <= cfg_data;
        default: ;
      endcase
    end
  end

  // Products and corner sums
  abbt_map u_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (start && !busy),
    .in_box      (in_box),
    .coef        (coef_r),
    .out_valid   (map_valid),
    .out_path    (map_path),
    .out_corners (crn)
  );

  // Bounds stage: shear-free ordering or four-corner min/max and exactness
  always_comb begin
    logic signed [COORD_WIDTH-1:0] q0, q1, q2, q3;
    logic signed [COORD_WIDTH-1:0] r0, r1, r2, r3;
    logic signed [COORD_WIDTH-1:0] mn_a, mn_b, mx_a, mx_b;
    logic signed [COORD_WIDTH-1:0] gx_lo, gx_hi, gy_lo, gy_hi;
    logic                          pat_a, pat_b;

    q0 = $signed(crn.qx[0]); q1 = $signed(crn.qx[1]);
    q2 = $signed(crn.qx[2]); q3 = $signed(crn.qx[3]);
    r0 = $signed(crn.qy[0]); r1 = $signed(crn.qy[1]);
    r2 = $signed(crn.qy[2]); r3 = $signed(crn.qy[3]);

    // x extremes over the four corners
    mn_a  = (q1 < q0) ? q1 : q0;
    mn_b  = (q3 < q2) ? q3 : q2;
    mx_a  = (q1 > q0) ? q1 : q0;
    mx_b  = (q3 > q2) ? q3 : q2;
    gx_lo = (mn_b < mn_a) ? mn_b : mn_a;
    gx_hi = (mx_b > mx_a) ? mx_b : mx_a;

    // y extremes over the four corners
    mn_a  = (r1 < r0) ? r1 : r0;
    mn_b  = (r3 < r2) ? r3 : r2;
    mx_a  = (r1 > r0) ? r1 : r0;
    mx_b  = (r3 > r2) ? r3 : r2;
    gy_lo = (mn_b < mn_a) ? mn_b : mn_a;
    gy_hi = (mx_b > mx_a) ? mx_b : mx_a;

    // the two axis-aligned corner patterns
    pat_a = (q1 == q0) && (r1 == r3) && (q2 == q3) && (r2 == r0);
    pat_b = (q1 == q3) && (r1 == r0) && (q2 == q0) && (r2 == r3);

    if (map_path.shear_free) begin
      // x ends are corners 0 and 1, y ends corners 0 and 2; unit scale keeps order
      if (map_path.xx_one || (q0 < q1)) begin
        out_res_nxt.out_x1 = q0;
        out_res_nxt.out_x2 = q1;
      end else begin
        out_res_nxt.out_x1 = q1;
        out_res_nxt.out_x2 = q0;
      end
      if (map_path.yy_one || (r0 < r2)) begin
        out_res_nxt.out_y1 = r0;
        out_res_nxt.out_y2 = r2;
      end else begin
        out_res_nxt.out_y1 = r2;
        out_res_nxt.out_y2 = r0;
      end
      out_res_nxt.box_exact = 1'b1;
    end else begin
      out_res_nxt.out_x1    = gx_lo;
      out_res_nxt.out_x2    = gx_hi;
      out_res_nxt.out_y1    = gy_lo;
      out_res_nxt.out_y2    = gy_hi;
      out_res_nxt.box_exact = pat_a || pat_b;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= map_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* sv/abbt_checker.sv */
// ----------------------------------------------------------------------------
// abbt_checker
// Port-level checks of latency, strobe origin and bound ordering.
// ----------------------------------------------------------------------------
module abbt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input abbt_pkg::box_out_t out_res
);
  import abbt_pkg::*;

  // every accepted beat produces a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result strobe missing three cycles after accept");

  // no strobe without a matching accepted beat
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result strobe without matching accept");

  // an inexact result comes from the four-corner path, which is ordered
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.box_exact) |->
      ($signed(out_res.out_x1) <= $signed(out_res.out_x2)) &&
      ($signed(out_res.out_y1) <= $signed(out_res.out_y2)))
    else $error("inexact result with unordered bounds");

endmodule

bind affine_bounding_box_transform_core abbt_checker u_abbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);

/* tb/tb_affine_bounding_box_transform_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_affine_bounding_box_transform_core
// Self-checking bench for the affine bounding box core. A directed table runs
// first: pass-through boxes, saturating offsets, negative, extreme and
// fractional scales, quarter turns, shears and ignored register indexes.
// Random phases follow, each with its own matrix style and input idle rate.
// Every result beat is checked against a table value or a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_affine_bounding_box_transform_core;
  import abbt_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int PIPE_DEPTH     = 3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 10;
  localparam int PHASE_BOXES    = 103;
  localparam int REPORT_LIMIT   = 10;
  localparam int PLAN_ROWS      = 35;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [CFG_IDX_W-1:0]          reg_idx_t;

  // indexes the register file does not decode
  localparam reg_idx_t CFG_SPARE_6 = reg_idx_t'(6);
  localparam reg_idx_t CFG_SPARE_7 = reg_idx_t'(7);

  localparam coord_t C_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t C_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam longint SAT_HI = longint'(C_MAX);
  localparam longint SAT_LO = longint'(C_MIN);

  localparam box_in_t  NO_BOX = '0;
  localparam box_out_t NO_RES = '0;

  typedef enum logic [1:0] {ROW_BOX, ROW_BOX_KNOWN, ROW_REG} row_kind_e;
  typedef enum int {MX_IDENTITY, MX_AXIS, MX_GENERAL, MX_QUARTER, MX_EXTREME}
    matrix_style_e;

  typedef struct packed {
    row_kind_e kind;
    reg_idx_t  idx;
    coord_t    val;
    box_in_t   box;
    box_out_t  known;
  } plan_row_t;

  // Directed plan: register writes and boxes, in order
  plan_row_t plan [PLAN_ROWS] = '{
    // identity after reset: corners pass through in input order
    '{ROW_BOX_KNOWN, '0, '0,
      {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000},
      {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 1'b1}},
    '{ROW_BOX_KNOWN, '0, '0, {C_MAX, C_MIN, C_MIN, C_MAX},
      {C_MAX, C_MIN, C_MIN, C_MAX, 1'b1}},
    '{ROW_BOX_KNOWN, '0, '0, NO_BOX, {{4{32'h0}}, 1'b1}},
    '{ROW_BOX_KNOWN, '0, '0,
      {32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_0001, 32'hFFFF_0000},
      {32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_0001, 32'hFFFF_0000, 1'b1}},
    // offsets that saturate
    '{ROW_REG, CFG_OFFSET_X, C_MAX, NO_BOX, NO_RES},
    '{ROW_BOX_KNOWN, '0, '0, {C_MAX, 32'h0, 32'hFFFF_FFFF, 32'h0},
      {C_MAX, 32'h0, 32'h7FFF_FFFE, 32'h0, 1'b1}},
    '{ROW_REG, CFG_OFFSET_Y, C_MIN, NO_BOX, NO_RES},
    '{ROW_BOX_KNOWN, '0, '0, {32'h0, C_MIN, 32'h0, 32'h0000_0001},
      {C_MAX, C_MIN, C_MAX, 32'h8000_0001, 1'b1}},
    '{ROW_REG, CFG_OFFSET_X, 32'h0, NO_BOX, NO_RES},
    '{ROW_REG, CFG_OFFSET_Y, 32'h0, NO_BOX, NO_RES},
    // negative scale swaps the ends
    '{ROW_REG, CFG_COEF_XX, 32'hFFFF_0000, NO_BOX, NO_RES},
    '{ROW_BOX, '0, '0, {32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0}, NO_RES},
    // most negative scale saturates the mapped ends
    '{ROW_REG, CFG_COEF_XX, C_MIN, NO_BOX, NO_RES},
    '{ROW_BOX, '0, '0, {C_MIN, 32'h5, C_MAX, 32'h7}, NO_RES},
    // half scale on odd raw values: floor rounding
    '{ROW_REG, CFG_COEF_XX, 32'h0000_8000, NO_BOX, NO_RES},
    '{ROW_BOX, '0, '0, {32'hFFFF_FFFF, 32'h7, 32'h0000_0001, 32'h3}, NO_RES},
    // zero scale on y
    '{ROW_REG, CFG_COEF_YY, 32'h0, NO_BOX, NO_RES},
    '{ROW_BOX, '0, '0, {32'h0001_0000, C_MAX, 32'h0, C_MIN}, NO_RES},
    // quarter turn: general path, still axis aligned
    '{ROW_REG, CFG_COEF_XX, 32'h0, NO_BOX, NO_RES},
    '{ROW_REG, CFG_COEF_YY, 32'h0, NO_BOX, NO_RES},
    '{ROW_REG, CFG_COEF_XY, 32'hFFFF_0000, NO_BOX, NO_RES},
    '{ROW_REG, CFG_COEF_YX, 32'h0001_0000, NO_BOX, NO_RES},
    '{ROW_BOX, '0, '0,
      {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0005_0000}, NO_RES},
    '{ROW_BOX, '0, '0, {C_MIN, C_MIN, C_MAX, C_MAX}, NO_RES},
    // plain shear: box is not exact
    '{ROW_REG, CFG_COEF_XX, 32'h0001_0000, NO_BOX, NO_RES},
    '{ROW_REG, CFG_COEF_YY, 32'h0001_0000, NO_BOX, NO_RES},
    '{ROW_REG, CFG_COEF_YX, 32'h0, NO_BOX, NO_RES},
    '{ROW_BOX, '0, '0, {32'h0, 32'h0, 32'h0002_0000, 32'h0003_0000}, NO_RES},
    '{ROW_BOX, '0, '0,
      {32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0003_0000}, NO_RES},
    // extreme shears
    '{ROW_REG, CFG_COEF_YX, C_MAX, NO_BOX, NO_RES},
    '{ROW_REG, CFG_COEF_XY, C_MIN, NO_BOX, NO_RES},
    '{ROW_BOX, '0, '0, {C_MAX, C_MIN, C_MIN, C_MAX}, NO_RES},
    // writes to undecoded indexes leave the matrix alone
    '{ROW_REG, CFG_SPARE_6, C_MAX, NO_BOX, NO_RES},
    '{ROW_REG, CFG_SPARE_7, C_MIN, NO_BOX, NO_RES},
    '{ROW_BOX, '0, '0,
      {32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000}, NO_RES}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     start     = 1'b0;
  logic     busy;
  box_in_t  in_box    = '0;
  logic     out_valid;
  box_out_t out_res;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  reg_idx_t cfg_index = '0;
  logic [COORD_WIDTH-1:0] cfg_data = '0;

  // bench copy of the matrix registers
  coord_t mat_xx  = FIX_ONE;
  coord_t mat_yx  = '0;
  coord_t mat_xy  = '0;
  coord_t mat_yy  = FIX_ONE;
  coord_t shift_x = '0;
  coord_t shift_y = '0;

  box_out_t expected_bounds [$];
  int       bound_errors = 0;
  int       stall_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  affine_bounding_box_transform_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_box    (in_box),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  // exact product, shifted toward minus infinity
  function automatic longint floor_product(coord_t a, coord_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FRAC_BITS;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > SAT_HI) return C_MAX;
    if (v < SAT_LO) return C_MIN;
    return coord_t'(v);
  endfunction

  // one axis without shear; unit scale keeps the input order
  function automatic void scale_axis(input coord_t scale, input coord_t off,
                                     input coord_t lo_in, input coord_t hi_in,
                                     output coord_t lo, output coord_t hi);
    coord_t a, b;
    if (scale != FIX_ONE) begin
      a  = clamp_coord(floor_product(lo_in, scale) + longint'(off));
      b  = clamp_coord(floor_product(hi_in, scale) + longint'(off));
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
    end else begin
      lo = clamp_coord(longint'(lo_in) + longint'(off));
      hi = clamp_coord(longint'(hi_in) + longint'(off));
    end
  endfunction

  function automatic box_out_t bound_box(box_in_t b);
    box_out_t r;
    coord_t   cx [4];
    coord_t   cy [4];
    coord_t   px, py;
    int       i;
    if (mat_xy == '0 && mat_yx == '0) begin
      scale_axis(mat_xx, shift_x, b.in_x1, b.in_x2, r.out_x1, r.out_x2);
      scale_axis(mat_yy, shift_y, b.in_y1, b.in_y2, r.out_y1, r.out_y2);
      r.box_exact = 1'b1;
    end else begin
      // corners: 0=(x1,y1) 1=(x2,y1) 2=(x1,y2) 3=(x2,y2)
      for (i = 0; i < 4; i++) begin
        px    = (i % 2 == 1) ? b.in_x2 : b.in_x1;
        py    = (i / 2 == 1) ? b.in_y2 : b.in_y1;
        cx[i] = clamp_coord(floor_product(mat_xx, px) + floor_product(mat_xy, py)
                            + longint'(shift_x));
        cy[i] = clamp_coord(floor_product(mat_yx, px) + floor_product(mat_yy, py)
                            + longint'(shift_y));
      end
      r.out_x1 = cx[0];
      r.out_x2 = cx[0];
      r.out_y1 = cy[0];
      r.out_y2 = cy[0];
      for (i = 1; i < 4; i++) begin
        if (cx[i] < r.out_x1) r.out_x1 = cx[i];
        if (cx[i] > r.out_x2) r.out_x2 = cx[i];
        if (cy[i] < r.out_y1) r.out_y1 = cy[i];
        if (cy[i] > r.out_y2) r.out_y2 = cy[i];
      end
      r.box_exact = (cx[1] == cx[0] && cy[1] == cy[3] &&
                     cx[2] == cx[3] && cy[2] == cy[0]) ||
                    (cx[1] == cx[3] && cy[1] == cy[0] &&
                     cx[2] == cx[0] && cy[2] == cy[3]);
    end
    return r;
  endfunction

  function automatic void note_reg(reg_idx_t idx, coord_t val);
    case (idx)
      CFG_COEF_XX:  mat_xx  = val;
      CFG_COEF_YX:  mat_yx  = val;
      CFG_COEF_XY:  mat_xy  = val;
      CFG_COEF_YY:  mat_yy  = val;
      CFG_OFFSET_X: shift_x = val;
      CFG_OFFSET_Y: shift_y = val;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic coord_t extreme_coord();
    case ($urandom_range(4))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      3:       return '1;
      default: return FIX_ONE;
    endcase
  endfunction

  // mostly moderate values so results stay in range, some raw and extreme
  function automatic coord_t random_coord();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return coord_t'($signed($urandom) >>> 4);
      5, 6, 7:       return coord_t'($urandom);
      default:       return extreme_coord();
    endcase
  endfunction

  function automatic coord_t random_scale();
    case ($urandom_range(5))
      0:       return FIX_ONE;
      1:       return -FIX_ONE;
      2, 3:    return coord_t'($signed($urandom) >>> 12);
      4:       return coord_t'($urandom);
      default: return $urandom_range(1) ? C_MAX : C_MIN;
    endcase
  endfunction

  // corners collapse onto each other now and then
  function automatic box_in_t random_box();
    box_in_t b;
    b.in_x1 = random_coord();
    b.in_y1 = random_coord();
    b.in_x2 = ($urandom_range(7) == 0) ? b.in_x1 : random_coord();
    b.in_y2 = ($urandom_range(7) == 0) ? b.in_y1 : random_coord();
    return b;
  endfunction

  // one register write beat; cfg_valid is left high for a following write
  task automatic write_reg(reg_idx_t idx, coord_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    note_reg(idx, val);
  endtask

  // hold input off until every pending box has come back
  task automatic settle();
    start <= 1'b0;
    while (expected_bounds.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 1) @(posedge clk);
  endtask

  task automatic send_box(box_in_t b, box_out_t bounds, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_box <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_bounds.push_back(bounds);
  endtask

  task automatic load_matrix(matrix_style_e style);
    coord_t m [6];
    coord_t k;
    int     r;
    m[CFG_OFFSET_X] = random_coord();
    m[CFG_OFFSET_Y] = random_coord();
    m[CFG_COEF_XX]  = FIX_ONE;
    m[CFG_COEF_YX]  = '0;
    m[CFG_COEF_XY]  = '0;
    m[CFG_COEF_YY]  = FIX_ONE;
    case (style)
      MX_AXIS: begin
        m[CFG_COEF_XX] = random_scale();
        m[CFG_COEF_YY] = random_scale();
      end
      MX_GENERAL: begin
        m[CFG_COEF_XX] = random_scale();
        m[CFG_COEF_YX] = random_scale();
        m[CFG_COEF_XY] = random_scale();
        m[CFG_COEF_YY] = random_scale();
      end
      MX_QUARTER: begin
        // rotation or mirror across a diagonal
        k = random_scale();
        m[CFG_COEF_XX] = '0;
        m[CFG_COEF_YY] = '0;
        m[CFG_COEF_YX] = k;
        m[CFG_COEF_XY] = $urandom_range(1) ? k : -k;
      end
      MX_EXTREME: begin
        for (r = 0; r < 6; r++) m[r] = extreme_coord();
      end
      default: ;
    endcase
    settle();
    for (r = 0; r < 6; r++) write_reg(reg_idx_t'(r), m[r]);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void flag_bounds(string what, box_out_t want, box_out_t got);
    bound_errors++;
    if (bound_errors <= REPORT_LIMIT)
      $display("%s at %0t: want %h %h %h %h %b, got %h %h %h %h %b", what, $realtime,
               want.out_x1, want.out_y1, want.out_x2, want.out_y2, want.box_exact,
               got.out_x1, got.out_y1, got.out_x2, got.out_y2, got.box_exact);
  endfunction

  // result beats against the oldest pending box
  always @(posedge clk) begin : result_check
    box_out_t want;
    if (rst_n && out_valid) begin
      if (expected_bounds.size() == 0) begin
        flag_bounds("unexpected result", NO_RES, out_res);
      end else begin
        want = expected_bounds.pop_front();
        if (out_res.out_x1 !== want.out_x1 || out_res.out_y1 !== want.out_y1 ||
            out_res.out_x2 !== want.out_x2 || out_res.out_y2 !== want.out_y2 ||
            out_res.box_exact !== want.box_exact)
          flag_bounds("bounds mismatch", want, out_res);
      end
    end
  end

  // watchdog: cycles without any accepted beat or result
  always @(posedge clk) begin
    if ((start && !busy && rst_n) || out_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_affine_bounding_box_transform_core failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int          r;
    int          p;
    int          n;
    int unsigned idle;
    box_in_t     b;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind == ROW_REG) begin
        if (r > 0 && plan[r-1].kind != ROW_REG) settle();
        write_reg(plan[r].idx, plan[r].val);
      end else begin
        if (r > 0 && plan[r-1].kind == ROW_REG) cfg_valid <= 1'b0;
        send_box(plan[r].box, (plan[r].kind == ROW_BOX_KNOWN) ? plan[r].known
                                                              : bound_box(plan[r].box), 0);
      end
    end

    // random phases: matrix style and input idle rate change per phase
    for (p = 0; p < PHASES; p++) begin
      load_matrix(matrix_style_e'(p % 5));
      idle = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 69 : 18;
      for (n = 0; n < PHASE_BOXES; n++) begin
        b = random_box();
        send_box(b, bound_box(b), idle);
      end
    end

    settle();
    if (bound_errors == 0)
      $display("tb_affine_bounding_box_transform_core passed");
    else
      $display("tb_affine_bounding_box_transform_core failed");
    $finish;
  end

endmodule

/* sim.f */
sv/abbt_pkg.sv
sv/abbt_map.sv
sv/affine_bounding_box_transform_core.sv
sv/abbt_checker.sv
tb/tb_affine_bounding_box_transform_core.sv
